// File: sv/srtq_pkg.sv
package srtq_pkg;

  localparam int QueueDepth = 32;
  localparam int SizeBits   = 40;
  localparam int AheadBits  = 48;
  localparam int TagBits    = 16;
  localparam int FracBits   = 16;
  localparam int AddrBits   = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int LhsBits    = AheadBits + 1 + 8;
  localparam int ProdBits   = FracBits + SizeBits;

  localparam logic [2:0] ST_APPEND  = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_DISCARD = 3'd2;
  localparam logic [2:0] ST_POP     = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  localparam logic [1:0] REG_REORDER = 2'd0;
  localparam logic [1:0] REG_FRAC    = 2'd1;
  localparam logic [1:0] REG_MAXLEN  = 2'd2;

  typedef struct packed {
    logic                func;
    logic [TagBits-1:0]  job_tag;
    logic [SizeBits-1:0] job_size;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [5:0]          position;
    logic [TagBits-1:0]  popped_tag;
    logic [SizeBits-1:0] popped_size;
    logic [5:0]          queue_count;
  } rsp_t;

  typedef struct packed {
    logic [TagBits-1:0]   tag;
    logic [SizeBits-1:0]  size;
    logic [AheadBits-1:0] ahead;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_MUL, S_SCAN_CMP, S_PLACE,
    S_POP_HEAD, S_POP_RD, S_POP_WR, S_INS_RD, S_INS_WR, S_PUT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_APPEND_POS, C_MUL, C_CMP, C_HEAD, C_POP_WR,
    C_INS_START, C_INS_WR, C_PUT, C_DONE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    rd_prev;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic empty;
    logic discard;
    logic reorder;
    logic idx_lt_cnt;
    logic idx_gt_pos;
    logic pos_lt_cnt;
    logic out_busy;
  } stat_t;

endpackage

// File: sv/srtq_ctrl.sv
module srtq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  srtq_pkg::stat_t stat,
  output srtq_pkg::cmd_t  cmd
);

  srtq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      srtq_pkg::S_IDLE: begin
        if (req_valid) state_next = srtq_pkg::S_DECIDE;
      end
      srtq_pkg::S_DECIDE: begin
        if (stat.func == srtq_pkg::FUNC_POP) begin
          state_next = stat.empty ? srtq_pkg::S_DONE : srtq_pkg::S_POP_HEAD;
        end else if (stat.discard) begin
          state_next = srtq_pkg::S_DONE;
        end else if (!stat.reorder || stat.empty) begin
          state_next = srtq_pkg::S_PUT;
        end else begin
          state_next = srtq_pkg::S_SCAN_RD;
        end
      end
      srtq_pkg::S_SCAN_RD: begin
        state_next = stat.idx_lt_cnt ? srtq_pkg::S_SCAN_MUL : srtq_pkg::S_PLACE;
      end
      srtq_pkg::S_SCAN_MUL: state_next = srtq_pkg::S_SCAN_CMP;
      srtq_pkg::S_SCAN_CMP: state_next = srtq_pkg::S_SCAN_RD;
      srtq_pkg::S_PLACE: begin
        state_next = stat.pos_lt_cnt ? srtq_pkg::S_INS_RD : srtq_pkg::S_PUT;
      end
      srtq_pkg::S_INS_RD: begin
        state_next = stat.idx_gt_pos ? srtq_pkg::S_INS_WR : srtq_pkg::S_PUT;
      end
      srtq_pkg::S_INS_WR: state_next = srtq_pkg::S_INS_RD;
      srtq_pkg::S_PUT:    state_next = srtq_pkg::S_DONE;
      srtq_pkg::S_POP_HEAD: state_next = srtq_pkg::S_POP_RD;
      srtq_pkg::S_POP_RD: begin
        state_next = stat.idx_lt_cnt ? srtq_pkg::S_POP_WR : srtq_pkg::S_DONE;
      end
      srtq_pkg::S_POP_WR: state_next = srtq_pkg::S_POP_RD;
      srtq_pkg::S_DONE: begin
        if (!stat.out_busy) state_next = srtq_pkg::S_IDLE;
      end
      default: state_next = srtq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = srtq_pkg::C_NONE;
    cmd.rd_prev = 1'b0;
    req_stall   = 1'b1;
    case (state)
      srtq_pkg::S_IDLE: begin
        req_stall = 1'b0;
        cmd.op    = req_valid ? srtq_pkg::C_LOAD : srtq_pkg::C_NONE;
      end
      srtq_pkg::S_DECIDE: begin
        if (stat.func == srtq_pkg::FUNC_INSERT && !stat.discard
            && (!stat.reorder || stat.empty)) begin
          cmd.op = srtq_pkg::C_APPEND_POS;
        end
      end
      srtq_pkg::S_SCAN_MUL: cmd.op = srtq_pkg::C_MUL;
      srtq_pkg::S_SCAN_CMP: cmd.op = srtq_pkg::C_CMP;
      srtq_pkg::S_PLACE:    cmd.op = srtq_pkg::C_INS_START;
      srtq_pkg::S_INS_RD:   cmd.rd_prev = 1'b1;
      srtq_pkg::S_INS_WR:   cmd.op = srtq_pkg::C_INS_WR;
      srtq_pkg::S_PUT:      cmd.op = srtq_pkg::C_PUT;
      srtq_pkg::S_POP_HEAD: cmd.op = srtq_pkg::C_HEAD;
      srtq_pkg::S_POP_WR:   cmd.op = srtq_pkg::C_POP_WR;
      srtq_pkg::S_DONE: begin
        if (!stat.out_busy) cmd.op = srtq_pkg::C_DONE;
      end
      default: cmd.op = srtq_pkg::C_NONE;
    endcase
  end

endmodule

// File: sv/srtq_dp.sv
module srtq_dp (
  input  logic            clk,
  input  logic            rst,
  input  srtq_pkg::req_t  req,
  input  srtq_pkg::cmd_t  cmd,
  output srtq_pkg::stat_t stat,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output srtq_pkg::rsp_t  rsp
);

  srtq_pkg::entry_t mem [srtq_pkg::QueueDepth];
  srtq_pkg::entry_t rd_q;
  srtq_pkg::entry_t wdata;
  logic [srtq_pkg::AddrBits-1:0] raddr, waddr;
  logic we;

  logic                          reorder;
  logic [srtq_pkg::FracBits-1:0] frac;
  logic [5:0]                    max_len;

  srtq_pkg::req_t                job;
  logic [srtq_pkg::CntBits-1:0]  cnt, idx, pos;
  logic [srtq_pkg::CntBits-1:0]  idx_prev;
  logic [srtq_pkg::LhsBits-1:0]  lhs;
  logic [srtq_pkg::ProdBits-1:0] prod;
  logic [srtq_pkg::TagBits-1:0]  ptag;
  logic [srtq_pkg::SizeBits-1:0] psize;
  logic [srtq_pkg::AheadBits:0]  ahead_sum;
  logic [srtq_pkg::AheadBits-1:0] ahead_sat;
  logic                          discard;

  assign idx_prev  = idx - 1'b1;
  assign raddr     = cmd.rd_prev ? idx_prev[srtq_pkg::AddrBits-1:0]
                                 : idx[srtq_pkg::AddrBits-1:0];
  assign ahead_sum = {1'b0, rd_q.ahead}
                   + (srtq_pkg::AheadBits + 1)'(job.job_size);
  assign ahead_sat = ahead_sum[srtq_pkg::AheadBits] ? '1
                   : ahead_sum[srtq_pkg::AheadBits-1:0];
  assign discard   = (6'(cnt) > max_len) || (cnt == srtq_pkg::CntBits'(srtq_pkg::QueueDepth));

  always_comb begin
    stat.func       = job.func;
    stat.empty      = (cnt == '0);
    stat.discard    = discard;
    stat.reorder    = reorder;
    stat.idx_lt_cnt = (idx < cnt);
    stat.idx_gt_pos = (idx > pos);
    stat.pos_lt_cnt = (pos < cnt);
    stat.out_busy   = rsp_valid && rsp_stall;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx[srtq_pkg::AddrBits-1:0];
    wdata = rd_q;
    case (cmd.op)
      srtq_pkg::C_POP_WR: begin
        we    = 1'b1;
        waddr = idx_prev[srtq_pkg::AddrBits-1:0];
      end
      srtq_pkg::C_INS_WR: begin
        we          = 1'b1;
        wdata.ahead = ahead_sat;
      end
      srtq_pkg::C_PUT: begin
        we          = 1'b1;
        waddr       = pos[srtq_pkg::AddrBits-1:0];
        wdata.tag   = job.job_tag;
        wdata.size  = job.job_size;
        wdata.ahead = '0;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reorder <= 1'b0;
      frac    <= 16'd512;
      max_len <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        srtq_pkg::REG_REORDER: reorder <= cfg_data[0];
        srtq_pkg::REG_FRAC:    frac    <= cfg_data;
        srtq_pkg::REG_MAXLEN:  max_len <= cfg_data[5:0];
        default: reorder <= reorder;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      srtq_pkg::C_LOAD: begin
        job   <= req;
        idx   <= '0;
        pos   <= '0;
        ptag  <= '0;
        psize <= '0;
      end
      srtq_pkg::C_APPEND_POS: pos <= cnt;
      srtq_pkg::C_MUL: begin
        lhs  <= {ahead_sum, 8'h00};
        prod <= srtq_pkg::ProdBits'(frac) * srtq_pkg::ProdBits'(rd_q.size);
      end
      srtq_pkg::C_CMP: begin
        if (lhs > srtq_pkg::LhsBits'(prod)) pos <= idx + 1'b1;
        idx <= idx + 1'b1;
      end
      srtq_pkg::C_INS_START: idx <= cnt;
      srtq_pkg::C_INS_WR:    idx <= idx_prev;
      srtq_pkg::C_HEAD: begin
        ptag  <= rd_q.tag;
        psize <= rd_q.size;
        idx   <= srtq_pkg::CntBits'(1);
      end
      srtq_pkg::C_POP_WR: idx <= idx + 1'b1;
      default: idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else if (cmd.op == srtq_pkg::C_DONE) begin
      rsp_valid       <= 1'b1;
      rsp.popped_tag  <= ptag;
      rsp.popped_size <= psize;
      rsp.position    <= '0;
      if (job.func == srtq_pkg::FUNC_POP) begin
        if (cnt == '0) begin
          rsp.status      <= srtq_pkg::ST_EMPTY;
          rsp.queue_count <= '0;
        end else begin
          rsp.status      <= srtq_pkg::ST_POP;
          rsp.queue_count <= 6'(cnt - 1'b1);
          cnt             <= cnt - 1'b1;
        end
      end else if (discard) begin
        rsp.status      <= srtq_pkg::ST_DISCARD;
        rsp.queue_count <= 6'(cnt);
      end else begin
        rsp.status      <= (pos >= cnt) ? srtq_pkg::ST_APPEND : srtq_pkg::ST_INSERT;
        rsp.position    <= 6'(pos);
        rsp.queue_count <= 6'(cnt + 1'b1);
        cnt             <= cnt + 1'b1;
      end
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: sv/size_reordering_transfer_queue_unit.sv
// channel | signals                          | direction | word
// req     | req_valid, req_stall, req        | in        | func, job_tag, job_size
// rsp     | rsp_valid, rsp_stall, rsp        | out       | status .. queue_count
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | register write
// One word at a time; a pop moves every later entry up one slot, and a reordering
// insert compares the job against every entry, then shifts the entries behind its
// position. The pace is set by the entry memory (one registered read and one
// write a cycle) and a registered multiply per compare.
// rst is synchronous; it empties the queue and restores register defaults.
// A stalled result holds; the next request is taken while it waits.
module size_reordering_transfer_queue_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  srtq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output srtq_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  srtq_pkg::cmd_t  cmd;
  srtq_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  srtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  srtq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: tb/tb.sv
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  srtq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  srtq_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  size_reordering_transfer_queue_unit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  localparam logic [47:0] AheadMax = 48'hFFFF_FFFF_FFFF;

  logic                           q_reorder;
  logic [15:0]                    q_frac;
  logic [5:0]                     q_maxlen;
  logic [srtq_pkg::TagBits-1:0]   q_tag[srtq_pkg::QueueDepth];
  logic [srtq_pkg::SizeBits-1:0]  q_size[srtq_pkg::QueueDepth];
  logic [srtq_pkg::AheadBits-1:0] q_ahead[srtq_pkg::QueueDepth];
  int                             q_count;

  srtq_pkg::rsp_t pending_rsp[$];
  int   n_words, n_rsp, n_err;
  bit   quiet;
  int   n_ins, n_reord, n_pop, n_disc;
  int   stall_left;

  function automatic srtq_pkg::rsp_t queue_op(srtq_pkg::req_t r);
    srtq_pkg::rsp_t o;
    int pos;
    logic [57:0] lhs, rhs;
    logic [48:0] s;
    o = '0;
    if (r.func == srtq_pkg::FUNC_POP) begin
      if (q_count == 0) begin
        o.status = srtq_pkg::ST_EMPTY;
      end else begin
        o.status = srtq_pkg::ST_POP;
        o.popped_tag = q_tag[0];
        o.popped_size = q_size[0];
        for (int i = 1; i < q_count; i++) begin
          q_tag[i-1] = q_tag[i];
          q_size[i-1] = q_size[i];
          q_ahead[i-1] = q_ahead[i];
        end
        q_count--;
      end
    end else if (q_count > q_maxlen || q_count >= srtq_pkg::QueueDepth) begin
      o.status = srtq_pkg::ST_DISCARD;
    end else begin
      pos = q_count;
      if (q_reorder) begin
        pos = 0;
        for (int i = 0; i < q_count; i++) begin
          lhs = ({9'd0, r.job_size} + {10'd0, q_ahead[i]}) << 8;
          rhs = {42'd0, q_frac} * {18'd0, q_size[i]};
          if (lhs > rhs) pos = i + 1;
        end
      end
      if (pos >= q_count) begin
        o.status = srtq_pkg::ST_APPEND;
        o.position = 6'(q_count);
      end else begin
        o.status = srtq_pkg::ST_INSERT;
        o.position = 6'(pos);
        for (int i = q_count; i > pos; i--) begin
          q_tag[i] = q_tag[i-1];
          q_size[i] = q_size[i-1];
          s = {1'b0, q_ahead[i-1]} + {9'd0, r.job_size};
          q_ahead[i] = s[48] ? AheadMax : s[47:0];
        end
      end
      q_tag[pos] = r.job_tag;
      q_size[pos] = r.job_size;
      q_ahead[pos] = '0;
      q_count++;
    end
    o.queue_count = 6'(q_count);
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      pending_rsp = {pending_rsp, queue_op(req)};
      n_words++;
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected rsp %p", rsp);
      end else begin
        srtq_pkg::rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status || rsp.position !== e.position ||
            rsp.popped_tag !== e.popped_tag || rsp.popped_size !== e.popped_size ||
            rsp.queue_count !== e.queue_count) begin
          n_err++;
          if (n_err <= 10) $display("mismatch exp %p got %p", e, rsp);
        end
        case (rsp.status)
          srtq_pkg::ST_INSERT: begin n_ins++; n_reord++; end
          srtq_pkg::ST_APPEND: n_ins++;
          srtq_pkg::ST_POP: n_pop++;
          srtq_pkg::ST_DISCARD: n_disc++;
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || rst) begin
      stall_left = 0;
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 2);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic send_word(logic f, logic [15:0] t, logic [39:0] sz);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: f, job_tag: t, job_size: sz};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      srtq_pkg::REG_REORDER: q_reorder = d[0];
      srtq_pkg::REG_FRAC: q_frac = d;
      srtq_pkg::REG_MAXLEN: q_maxlen = d[5:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic re, logic [15:0] fr, logic [5:0] ml);
    drain();
    write_reg(srtq_pkg::REG_REORDER, {15'd0, re});
    write_reg(srtq_pkg::REG_FRAC, fr);
    write_reg(srtq_pkg::REG_MAXLEN, {10'd0, ml});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [39:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 40'd0;
      1: return 40'hFF_FFFF_FFFF;
      2: return 40'($urandom_range(0, 15));
      3: return 40'({$urandom, $urandom});
      default: return 40'($urandom_range(1, 5000));
    endcase
  endfunction

  task automatic flush_queue();
    while (q_count > 0) send_word(srtq_pkg::FUNC_POP, 16'($urandom), 40'({$urandom, $urandom}));
  endtask

  task automatic test_directed();
    send_word(srtq_pkg::FUNC_POP, 16'hFFFF, 40'hFF_FFFF_FFFF);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0000, 40'd0);
    send_word(srtq_pkg::FUNC_INSERT, 16'hFFFF, 40'hFF_FFFF_FFFF);
    send_word(srtq_pkg::FUNC_POP, 16'd0, 40'd0);
    send_word(srtq_pkg::FUNC_POP, 16'd0, 40'd0);
    set_config(1'b1, 16'd512, 6'd32);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0001, 40'd1000);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0002, 40'd10);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0003, 40'd0);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0004, 40'd0);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0005, 40'd5);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0006, 40'hFF_FFFF_FFFF);
    send_word(srtq_pkg::FUNC_INSERT, 16'h0007, 40'd1);
    flush_queue();
  endtask

  task automatic test_saturation();
    set_config(1'b1, 16'hFFFF, 6'd32);
    send_word(srtq_pkg::FUNC_INSERT, 16'hAAAA, 40'hFF_FFFF_FFFF);
    repeat (300) send_word(srtq_pkg::FUNC_INSERT, 16'($urandom), 40'hFF_FFFF_FFFF);
    flush_queue();
  endtask

  task automatic test_full();
    set_config(1'b0, 16'd0, 6'd32);
    repeat (34) send_word(srtq_pkg::FUNC_INSERT, 16'($urandom), rand_size());
    flush_queue();
    set_config(1'b1, 16'd0, 6'd0);
    repeat (3) send_word(srtq_pkg::FUNC_INSERT, 16'($urandom), rand_size());
    flush_queue();
    set_config(1'b1, 16'd256, 6'd5);
    repeat (8) send_word(srtq_pkg::FUNC_INSERT, 16'($urandom), rand_size());
    flush_queue();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 200 == 0)
        set_config($urandom_range(0, 3) != 0,
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024)),
                   $urandom_range(0, 5) == 0 ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(10, 32)));
      if (k >= n - 150) quiet = 1'b1;
      if ($urandom_range(0, 99) < (q_count > 20 ? 50 : 30))
        send_word(srtq_pkg::FUNC_POP, 16'($urandom), 40'({$urandom, $urandom}));
      else
        send_word(srtq_pkg::FUNC_INSERT, 16'($urandom), rand_size());
    end
  endtask

  initial begin
    q_reorder = 1'b0; q_frac = 16'd512; q_maxlen = 6'd32; q_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full();
    test_saturation();
    test_random(920);
    drain();
    $display("%0d words, %0d results: %0d inserts (%0d reordered), %0d pops, %0d discards",
             n_words, n_rsp, n_ins, n_reord, n_pop, n_disc);
    $display("mismatches: %0d", n_err);
    if (n_err == 0 && pending_rsp.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
